@@ sv/bcd_pkg.sv @@
// Shared types, constants and drive curve for the breath cycle drive sequencer.
package bcd_pkg;

	localparam int TICK_W    = 12;
	localparam int PRESS_W   = 10;
	localparam int TIDAL_W   = 10;
	localparam int DRIVE_W   = 10;
	localparam int CFG_W     = 12;
	localparam int CFG_IDX_W = 3;
	localparam int POS_W     = 7;
	localparam int ROM_W     = 10;
	localparam int DIV_W     = 20;
	localparam int QUO_W     = 11;
	localparam int CNT_W     = 4;

	localparam int TIDAL_FULL_SCALE = 700;

	// reciprocal of the full scale tidal volume; exact for every 20-bit curve product
	localparam int RECIP_W     = 21;
	localparam int RECIP_SHIFT = 30;
	localparam int PROD_W      = DIV_W + RECIP_W;

	localparam logic [TICK_W-1:0]  TICK_MAX         = '1;
	localparam logic [TICK_W-1:0]  RST_INHALE_TICKS = 12'd200;
	localparam logic [TICK_W-1:0]  RST_EXHALE_TICKS = 12'd200;
	localparam logic [TIDAL_W-1:0] RST_TIDAL        = 10'd250;
	localparam logic [PRESS_W-1:0] RST_THRESHOLD    = 10'd80;

	localparam logic [POS_W-1:0]   POS_FULL    = 7'd100;
	localparam logic [CNT_W-1:0]   POS_STEPS   = CNT_W'(POS_W);
	localparam logic [RECIP_W-1:0] SCALE_RECIP =
		RECIP_W'((2 ** RECIP_SHIFT + TIDAL_FULL_SCALE - 1) / TIDAL_FULL_SCALE);
	localparam logic [DRIVE_W-1:0] DRIVE_MAX   = '1;

	typedef enum logic {
		PH_INHALE = 1'b0,
		PH_EXHALE = 1'b1
	} phase_t;

	typedef enum logic [CFG_IDX_W-1:0] {
		CFG_INHALE_TICKS = 3'd0,
		CFG_EXHALE_TICKS = 3'd1,
		CFG_TIDAL        = 3'd2,
		CFG_SPONT        = 3'd3,
		CFG_THRESHOLD    = 3'd4
	} cfg_idx_t;

	typedef enum logic [2:0] {
		S_IDLE,
		S_POS,
		S_MUL,
		S_SCALE,
		S_FINISH
	} state_t;

	typedef struct packed {
		logic             load;
		logic [DIV_W-1:0] num;
		logic [DIV_W-1:0] den;
		logic [CNT_W-1:0] steps;
	} div_cmd_t;

	localparam logic [ROM_W-1:0] DRIVE_CURVE [101] = '{
		10'd0,   10'd5,   10'd10,  10'd15,  10'd20,  10'd25,  10'd30,  10'd35,  10'd40,  10'd45,
		10'd50,  10'd55,  10'd60,  10'd65,  10'd70,  10'd75,  10'd80,  10'd85,  10'd90,  10'd95,
		10'd100, 10'd105, 10'd110, 10'd115, 10'd120, 10'd125, 10'd130, 10'd135, 10'd140, 10'd145,
		10'd150, 10'd155, 10'd160, 10'd165, 10'd170, 10'd175, 10'd180, 10'd185, 10'd190, 10'd195,
		10'd200, 10'd217, 10'd235, 10'd252, 10'd270, 10'd287, 10'd305, 10'd322, 10'd340, 10'd357,
		10'd375, 10'd392, 10'd410, 10'd427, 10'd445, 10'd462, 10'd480, 10'd497, 10'd515, 10'd532,
		10'd550, 10'd567, 10'd585, 10'd602, 10'd620, 10'd637, 10'd655, 10'd672, 10'd690, 10'd707,
		10'd725, 10'd742, 10'd760, 10'd777, 10'd795, 10'd812, 10'd830, 10'd847, 10'd865, 10'd882,
		10'd900, 10'd906, 10'd912, 10'd918, 10'd924, 10'd930, 10'd936, 10'd943, 10'd949, 10'd955,
		10'd961, 10'd967, 10'd973, 10'd979, 10'd986, 10'd992, 10'd998, 10'd1004, 10'd1010, 10'd1016,
		10'd1023
	};

	function automatic logic [ROM_W-1:0] drive_curve(input logic [POS_W-1:0] pos);
		logic [ROM_W-1:0] v;
		if (pos > POS_FULL) begin
			v = DRIVE_CURVE[POS_FULL];
		end else begin
			v = DRIVE_CURVE[pos];
		end
		return v;
	endfunction

endpackage

@@ sv/bcd_div.sv @@
// Restoring divider: one compare and subtract per cycle.
module bcd_div (
	input  logic                        clk,
	input  logic                        arst_n,
	input  bcd_pkg::div_cmd_t           cmd,
	output logic                        busy,
	output logic [bcd_pkg::QUO_W-1:0]   quo
);
	import bcd_pkg::*;

	logic [DIV_W-1:0] rem_q;
	logic [DIV_W-1:0] den_q;
	logic [QUO_W-1:0] quo_q;
	logic [CNT_W-1:0] cnt_q;
	logic             busy_q;
	logic             ge;

	assign ge   = (rem_q >= den_q);
	assign busy = busy_q;
	assign quo  = quo_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			busy_q <= 1'b0;
			cnt_q  <= '0;
		end else if (cmd.load) begin
			busy_q <= 1'b1;
			cnt_q  <= cmd.steps - 1'b1;
		end else if (busy_q) begin
			if (cnt_q == '0) begin
				busy_q <= 1'b0;
			end else begin
				cnt_q <= cnt_q - 1'b1;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (cmd.load) begin
			rem_q <= cmd.num;
			den_q <= cmd.den;
			quo_q <= '0;
		end else if (busy_q) begin
			if (ge) begin
				rem_q <= rem_q - den_q;
			end
			quo_q <= {quo_q[QUO_W-2:0], ge};
			den_q <= den_q >> 1;
		end
	end

endmodule

@@ sv/breath_cycle_drive_sequencer.sv @@
// Breath cycle drive sequencer top level: settings, phase sequencer and result register.
// Flow: an exhale tick goes from acceptance straight to the result write; an inhale tick
// first runs 7 divider steps for the curve position (skipped when the position is full),
// then takes the position, forms the curve product, scales it by reciprocal multiply and writes it.
// No new tick is taken until the last one is written, and the write waits while the result
// register is stalled; a new tick is taken while the last result waits.
// Reset: asynchronous, active low; settings and active copies return to their defaults.
module breath_cycle_drive_sequencer (
	input  logic                          clk,
	input  logic                          arst_n,
	input  logic                          tick_valid,
	output logic                          tick_stall,
	input  logic [bcd_pkg::PRESS_W-1:0]   pressure_raw,
	input  logic                          settings_waiting,
	output logic                          result_valid,
	input  logic                          result_stall,
	output logic [bcd_pkg::DRIVE_W-1:0]   drive_value,
	output logic                          inhaling,
	output logic                          patient_triggered,
	output logic                          settings_taken,
	input  logic                          cfg_valid,
	output logic                          cfg_ready,
	input  logic [bcd_pkg::CFG_IDX_W-1:0] cfg_index,
	input  logic [bcd_pkg::CFG_W-1:0]     cfg_data
);
	import bcd_pkg::*;

	// settings
	logic [TICK_W-1:0]  new_inhale_q;
	logic [TICK_W-1:0]  new_exhale_q;
	logic [TIDAL_W-1:0] new_tidal_q;
	logic               spont_q;
	logic [PRESS_W-1:0] thresh_q;

	// breath state
	logic [TICK_W-1:0]  tick_q;
	phase_t             phase_q;
	logic [TICK_W-1:0]  act_inhale_q;
	logic [TICK_W-1:0]  act_exhale_q;
	logic [TIDAL_W-1:0] act_tidal_q;
	logic               pending_q;
	state_t             state_q;
	state_t             state_d;

	// per-tick work
	logic               trig_q;
	logic [POS_W-1:0]   pos_q;
	logic [DIV_W-1:0]   prod_q;
	logic [DRIVE_W-1:0] drive_q;

	// result register
	logic               result_valid_q;
	logic [DRIVE_W-1:0] drive_value_q;
	logic               inhaling_q;
	logic               triggered_q;
	logic               taken_q;

	logic               accept;
	logic               fin_go;
	logic [TICK_W-1:0]  tick_inc;
	logic               fire;
	logic [TICK_W-1:0]  tick_a;
	phase_t             phase_a;
	logic               pos_full_a;
	logic [DIV_W-1:0]   pos_num;
	logic [DIV_W-1:0]   scale_num;
	logic [PROD_W-1:0]  recip_prod;
	logic [QUO_W-1:0]   scale_quo;
	logic               inh_to;
	phase_t             phase_m;
	logic [TICK_W-1:0]  tick_m;
	logic               exh_to;
	phase_t             phase_f;
	logic [TICK_W-1:0]  tick_f;
	logic               swap;
	logic [DRIVE_W-1:0] drive_clamped;

	div_cmd_t           div_cmd;
	logic               div_busy;
	logic [QUO_W-1:0]   div_quo;

	bcd_div u_div (
		.clk    (clk),
		.arst_n (arst_n),
		.cmd    (div_cmd),
		.busy   (div_busy),
		.quo    (div_quo)
	);

	assign cfg_ready = 1'b1;

	// tick advance and spontaneous trigger, seen at acceptance
	assign tick_inc   = (tick_q == TICK_MAX) ? tick_q : tick_q + 1'b1;
	assign fire       = spont_q && (phase_q == PH_EXHALE) && (pressure_raw <= thresh_q);
	assign tick_a     = fire ? '0 : tick_inc;
	assign phase_a    = fire ? PH_INHALE : phase_q;
	assign pos_full_a = (tick_a >= act_inhale_q);
	assign pos_num    = DIV_W'(tick_a) * DIV_W'(POS_FULL);
	assign scale_num  = DIV_W'(drive_curve(pos_q)) * DIV_W'(act_tidal_q);

	// divide the curve product by the full scale tidal volume
	assign recip_prod = PROD_W'(prod_q) * PROD_W'(SCALE_RECIP);
	assign scale_quo  = recip_prod[RECIP_SHIFT +: QUO_W];

	// phase timeouts, applied when the result is written
	assign inh_to  = (phase_q == PH_INHALE) && ((tick_q >= act_inhale_q) || (tick_q == TICK_MAX));
	assign phase_m = inh_to ? PH_EXHALE : phase_q;
	assign tick_m  = inh_to ? '0 : tick_q;
	assign exh_to  = (phase_m == PH_EXHALE)
		&& ((tick_m >= act_exhale_q) || (tick_m == TICK_MAX));
	assign phase_f = exh_to ? PH_INHALE : phase_m;
	assign tick_f  = exh_to ? '0 : tick_m;
	assign swap    = exh_to && pending_q;

	assign drive_clamped = (scale_quo > QUO_W'(DRIVE_MAX)) ? DRIVE_MAX : scale_quo[DRIVE_W-1:0];

	assign fin_go = !result_valid_q || !result_stall;

	always_comb begin
		state_d = state_q;
		unique case (state_q)
			S_IDLE: begin
				if (accept) begin
					if (phase_a == PH_EXHALE) begin
						state_d = S_FINISH;
					end else if (pos_full_a) begin
						state_d = S_MUL;
					end else begin
						state_d = S_POS;
					end
				end
			end
			S_POS: begin
				if (!div_busy) begin
					state_d = S_MUL;
				end
			end
			S_MUL: begin
				state_d = S_SCALE;
			end
			S_SCALE: begin
				state_d = S_FINISH;
			end
			S_FINISH: begin
				if (fin_go) begin
					state_d = S_IDLE;
				end
			end
			default: begin
				state_d = S_IDLE;
			end
		endcase
	end

	always_comb begin
		tick_stall    = 1'b1;
		div_cmd.load  = 1'b0;
		div_cmd.num   = pos_num;
		div_cmd.den   = DIV_W'(act_inhale_q) << (POS_W - 1);
		div_cmd.steps = POS_STEPS;
		unique case (state_q)
			S_IDLE: begin
				tick_stall   = 1'b0;
				div_cmd.load = tick_valid && (phase_a == PH_INHALE) && !pos_full_a;
			end
			S_POS, S_MUL, S_SCALE, S_FINISH: begin
				tick_stall = 1'b1;
			end
			default: begin
				tick_stall = 1'b1;
			end
		endcase
	end

	assign accept = tick_valid && !tick_stall;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q        <= S_IDLE;
			new_inhale_q   <= RST_INHALE_TICKS;
			new_exhale_q   <= RST_EXHALE_TICKS;
			new_tidal_q    <= RST_TIDAL;
			spont_q        <= 1'b0;
			thresh_q       <= RST_THRESHOLD;
			tick_q         <= '0;
			phase_q        <= PH_INHALE;
			act_inhale_q   <= RST_INHALE_TICKS;
			act_exhale_q   <= RST_EXHALE_TICKS;
			act_tidal_q    <= RST_TIDAL;
			pending_q      <= 1'b0;
			result_valid_q <= 1'b0;
		end else begin
			state_q <= state_d;
			if (cfg_valid && cfg_ready) begin
				unique case (cfg_index)
					CFG_INHALE_TICKS: new_inhale_q <= cfg_data;
					CFG_EXHALE_TICKS: new_exhale_q <= cfg_data;
					CFG_TIDAL:        new_tidal_q  <= cfg_data[TIDAL_W-1:0];
					CFG_SPONT:        spont_q      <= cfg_data[0];
					CFG_THRESHOLD:    thresh_q     <= cfg_data[PRESS_W-1:0];
					default: begin
					end
				endcase
			end
			if (accept) begin
				pending_q <= pending_q | settings_waiting;
				tick_q    <= tick_a;
				phase_q   <= phase_a;
			end
			if ((state_q == S_FINISH) && fin_go) begin
				tick_q         <= tick_f;
				phase_q        <= phase_f;
				result_valid_q <= 1'b1;
				if (swap) begin
					act_inhale_q <= new_inhale_q;
					act_exhale_q <= new_exhale_q;
					act_tidal_q  <= new_tidal_q;
					pending_q    <= 1'b0;
				end
			end else if (result_valid_q && !result_stall) begin
				result_valid_q <= 1'b0;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (accept) begin
			trig_q  <= fire;
			drive_q <= '0;
			if (pos_full_a) begin
				pos_q <= POS_FULL;
			end
		end
		if ((state_q == S_POS) && !div_busy) begin
			pos_q <= div_quo[POS_W-1:0];
		end
		if (state_q == S_MUL) begin
			prod_q <= scale_num;
		end
		if (state_q == S_SCALE) begin
			drive_q <= drive_clamped;
		end
		if ((state_q == S_FINISH) && fin_go) begin
			drive_value_q <= drive_q;
			inhaling_q    <= (phase_f == PH_INHALE);
			triggered_q   <= trig_q;
			taken_q       <= swap;
		end
	end

	assign result_valid      = result_valid_q;
	assign drive_value       = drive_value_q;
	assign inhaling          = inhaling_q;
	assign patient_triggered = triggered_q;
	assign settings_taken    = taken_q;

	a_accept_leaves_idle: assert property (@(posedge clk) disable iff (!arst_n)
		accept |=> (state_q != S_IDLE))
		else $error("accepted word did not start the sequencer");

	a_taken_means_inhale: assert property (@(posedge clk) disable iff (!arst_n)
		(result_valid && settings_taken) |-> inhaling)
		else $error("settings swapped without a new inhale");

	a_scale_only_inhale: assert property (@(posedge clk) disable iff (!arst_n)
		((state_q == S_POS) || (state_q == S_SCALE)) |-> (phase_q == PH_INHALE))
		else $error("drive computed during exhale");

	a_div_done_in_wait: assert property (@(posedge clk) disable iff (!arst_n)
		$fell(div_busy) |-> (state_q == S_POS))
		else $error("divider finished outside the position wait");

endmodule
